@@ rtl/assert_macros.svh @@
// Assertion helpers used by the frame timer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ftt_pkg.sv @@
// ----------------------------------------------------------------------------
// ftt_pkg
// Types, constants and helpers shared by the frame timer files.
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int MAX_STEPS_PER_FRAME = 8;
    localparam int WINDOW_US           = 1000000;
    localparam int DIV_STEPS           = 64;
    localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

    localparam logic [1:0]  REG_TIME_SCALE = 2'd0;
    localparam logic [1:0]  REG_MAX_DELTA  = 2'd1;
    localparam logic [1:0]  REG_FIXED_STEP = 2'd2;

    localparam logic [15:0] TIME_SCALE_RST = 16'd256;
    localparam logic [23:0] MAX_DELTA_RST  = 24'd250000;
    localparam logic [23:0] FIXED_STEP_RST = 24'd16667;
    localparam logic [31:0] FPS_NUM        = 32'd256000000;
    localparam logic [39:0] ACC_MAX        = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    function automatic logic [23:0] sat24(input logic [63:0] v);
        return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

endpackage

@@ rtl/ftt_if.sv @@
// ----------------------------------------------------------------------------
// ftt channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface ftt_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [23:0] frame_delta;
    modport source (output valid, op, frame_delta, input ready);
    modport sink   (input valid, op, frame_delta, output ready);
endinterface

interface ftt_result_if;
    logic        valid;
    logic        ready;
    logic        step_granted;
    logic        time_discarded;
    logic [23:0] unscaled_delta;
    logic [31:0] scaled_delta;
    logic [63:0] elapsed_us;
    logic [63:0] scaled_elapsed_us;
    logic [63:0] frame_number;
    logic [23:0] frames_per_second;
    logic [23:0] average_frame_us;
    logic [23:0] fixed_alpha;
    modport source (output valid, step_granted, time_discarded, unscaled_delta,
                    scaled_delta, elapsed_us, scaled_elapsed_us, frame_number,
                    frames_per_second, average_frame_us, fixed_alpha,
                    input ready);
    modport sink   (input valid, step_granted, time_discarded, unscaled_delta,
                    scaled_delta, elapsed_us, scaled_elapsed_us, frame_number,
                    frames_per_second, average_frame_us, fixed_alpha,
                    output ready);
endinterface

interface ftt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fixed_timestep_frame_timer_core.sv @@
// ----------------------------------------------------------------------------
// fixed_timestep_frame_timer_core
// Frame timer with fixed-step accumulator, window statistics and alpha.
// ----------------------------------------------------------------------------
// The block takes one word at a time and is not ready until its result has
// been loaded into the output register. Its divisions share one restoring
// divider: a step request runs the alpha division, a step request that
// discards time runs a modulo and then alpha, a frame update scales its
// delta and runs alpha, and a frame update that closes a one-second window
// runs the rate, mean and alpha divisions. Register writes are taken at once.
module fixed_timestep_frame_timer_core (
    input logic         clk,
    input logic         rst_n,
    ftt_item_if.sink    item,
    ftt_result_if.source result,
    ftt_cfg_if.sink     cfg
);
    import ftt_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCALE    = 4'd1;
    localparam logic [3:0] S_WIN      = 4'd2;
    localparam logic [3:0] S_FPSMUL   = 4'd3;
    localparam logic [3:0] S_FPSDIV   = 4'd4;
    localparam logic [3:0] S_MEANDIV  = 4'd5;
    localparam logic [3:0] S_MOD      = 4'd6;
    localparam logic [3:0] S_ALPHA_GO = 4'd7;
    localparam logic [3:0] S_ALPHA    = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [15:0] time_scale_reg;
    logic [23:0] max_delta_reg;
    logic [23:0] fixed_step_reg;
    logic [63:0] total_elapsed_reg;
    logic [63:0] scaled_total_reg;
    logic [63:0] frames_seen_reg;
    logic [39:0] acc_reg;
    logic [3:0]  steps_reg;
    logic [31:0] window_time_reg;
    logic [31:0] window_frames_reg;
    logic [23:0] fps_reg;
    logic [23:0] mean_reg;
    logic [23:0] last_unscaled_reg;
    logic [31:0] last_scaled_reg;
    logic        granted_reg;
    logic        discarded_reg;
    logic [23:0] alpha_reg;
    logic        out_valid_reg;

    logic        item_fire;
    logic        out_free;
    logic [23:0] d_clamp;
    logic        acc_ge_step;
    logic        budget_spent;
    logic        window_done;
    logic [31:0] scaled;
    logic [40:0] acc_sum;
    logic        mul_en;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    ftt_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ftt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item.ready   = (state_reg == S_IDLE);
    assign item_fire    = item.valid && item.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;
    assign d_clamp      = (item.frame_delta > max_delta_reg) ? max_delta_reg
                                                             : item.frame_delta;
    assign acc_ge_step  = acc_reg >= {16'd0, fixed_step_reg};
    assign budget_spent = steps_reg >= 4'(MAX_STEPS_PER_FRAME);
    assign window_done  = window_time_reg >= 32'(WINDOW_US);
    assign scaled       = mul_p[39:8];
    assign acc_sum      = {1'b0, acc_reg} + {9'd0, scaled};

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = {8'd0, d_clamp};
        mul_b  = {16'd0, time_scale_reg};
        if (state_reg == S_IDLE)
        begin
            mul_en = item_fire && !item.op;
        end
        else if (state_reg == S_WIN)
        begin
            mul_en = window_done;
            mul_a  = window_frames_reg;
            mul_b  = FPS_NUM;
        end
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {8'd0, acc_reg, 16'd0};
        div_req.divisor  = {8'd0, fixed_step_reg};
        case (state_reg)
            S_IDLE:
            begin
                div_req.start    = item_fire && item.op && acc_ge_step && budget_spent;
                div_req.dividend = {24'd0, acc_reg};
            end
            S_FPSMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p;
                div_req.divisor  = window_time_reg;
            end
            S_FPSDIV:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {32'd0, window_time_reg};
                div_req.divisor  = window_frames_reg;
            end
            S_ALPHA_GO:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    if (!item.op)
                    begin
                        state_next = S_SCALE;
                    end
                    else if (acc_ge_step && budget_spent)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_ALPHA_GO;
                    end
                end
            end
            S_SCALE:    state_next = S_WIN;
            S_WIN:      state_next = window_done ? S_FPSMUL : S_ALPHA_GO;
            S_FPSMUL:   state_next = S_FPSDIV;
            S_FPSDIV:   state_next = div_rsp.done ? S_MEANDIV : S_FPSDIV;
            S_MEANDIV:  state_next = div_rsp.done ? S_ALPHA_GO : S_MEANDIV;
            S_MOD:      state_next = div_rsp.done ? S_ALPHA_GO : S_MOD;
            S_ALPHA_GO: state_next = S_ALPHA;
            S_ALPHA:    state_next = div_rsp.done ? S_OUT : S_ALPHA;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            time_scale_reg    <= TIME_SCALE_RST;
            max_delta_reg     <= MAX_DELTA_RST;
            fixed_step_reg    <= FIXED_STEP_RST;
            total_elapsed_reg <= '0;
            scaled_total_reg  <= '0;
            frames_seen_reg   <= '0;
            acc_reg           <= '0;
            steps_reg         <= '0;
            window_time_reg   <= '0;
            window_frames_reg <= '0;
            fps_reg           <= '0;
            mean_reg          <= '0;
            last_unscaled_reg <= '0;
            last_scaled_reg   <= '0;
            granted_reg       <= 1'b0;
            discarded_reg     <= 1'b0;
            alpha_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Zero writes to the delta limit or the step length are dropped.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TIME_SCALE: time_scale_reg <= cfg.data[15:0];
                    REG_MAX_DELTA:
                    begin
                        if (cfg.data != '0)
                        begin
                            max_delta_reg <= cfg.data;
                        end
                    end
                    REG_FIXED_STEP:
                    begin
                        if (cfg.data != '0)
                        begin
                            fixed_step_reg <= cfg.data;
                        end
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        granted_reg   <= item.op && acc_ge_step && !budget_spent;
                        discarded_reg <= item.op && acc_ge_step && budget_spent;
                        if (!item.op)
                        begin
                            last_unscaled_reg <= d_clamp;
                        end
                        else if (acc_ge_step && !budget_spent)
                        begin
                            acc_reg   <= acc_reg - {16'd0, fixed_step_reg};
                            steps_reg <= steps_reg + 1'b1;
                        end
                    end
                end
                S_SCALE:
                begin
                    last_scaled_reg   <= scaled;
                    total_elapsed_reg <= total_elapsed_reg + {40'd0, last_unscaled_reg};
                    scaled_total_reg  <= scaled_total_reg + {32'd0, scaled};
                    frames_seen_reg   <= frames_seen_reg + 1'b1;
                    acc_reg           <= acc_sum[40] ? ACC_MAX : acc_sum[39:0];
                    steps_reg         <= '0;
                    window_time_reg   <= window_time_reg + {8'd0, last_unscaled_reg};
                    if (window_frames_reg != '1)
                    begin
                        window_frames_reg <= window_frames_reg + 1'b1;
                    end
                end
                S_FPSDIV:
                begin
                    if (div_rsp.done)
                    begin
                        fps_reg <= sat24(div_rsp.quot);
                    end
                end
                S_MEANDIV:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg          <= sat24(div_rsp.quot);
                        window_time_reg   <= '0;
                        window_frames_reg <= '0;
                    end
                end
                S_MOD:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg <= {16'd0, div_rsp.rem[23:0]};
                    end
                end
                S_ALPHA:
                begin
                    if (div_rsp.done)
                    begin
                        alpha_reg <= sat24(div_rsp.quot);
                    end
                end
                default: ;
            endcase
        end
    end

    // The output word is loaded from the live state as it leaves the sequencer.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            result.step_granted      <= granted_reg;
            result.time_discarded    <= discarded_reg;
            result.unscaled_delta    <= last_unscaled_reg;
            result.scaled_delta      <= last_scaled_reg;
            result.elapsed_us        <= total_elapsed_reg;
            result.scaled_elapsed_us <= scaled_total_reg;
            result.frame_number      <= frames_seen_reg;
            result.frames_per_second <= fps_reg;
            result.average_frame_us  <= mean_reg;
            result.fixed_alpha       <= alpha_reg;
        end
    end

    assign result.valid = out_valid_reg;

    `ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `ASSERT_IMPL(a_grant_xor_discard, clk, rst_n, out_valid_reg,
        !(result.step_granted && result.time_discarded),
        "grant and discard in one word")
    `ASSERT_NEXT(a_grant_counts, clk, rst_n,
        item_fire && item.op && acc_ge_step && !budget_spent,
        steps_reg == $past(steps_reg) + 4'd1,
        "granted step not counted")
endmodule

@@ rtl/ftt_mul.sv @@
// ----------------------------------------------------------------------------
// ftt_mul
// Shared 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module ftt_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;
endmodule

@@ rtl/ftt_div.sv @@
// ----------------------------------------------------------------------------
// ftt_div
// Shared restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module ftt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ftt_pkg::div_req_t req,
    output ftt_pkg::div_rsp_t rsp
);
    import ftt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          quo_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          dvs_reg;
    logic [32:0]          trial;
    logic [32:0]          diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule
